// ----- rtl/lztd_pkg.sv -----
// Shared types and constants of the LZ77 triple decoder.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package lztd_pkg;

  // Field widths of one input item and one result item
  localparam int unsigned DIST_W = 8;
  localparam int unsigned LEN_W = 4;
  localparam int unsigned BYTE_W = 8;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 8;

  // Parameter defaults
  localparam int unsigned WINDOW_SIZE_DEF = 255;
  localparam int unsigned MAX_MATCH_DEF = 15;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new triple and issue its first history read
    logic step;  // emit one byte and append it to the history
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register is empty or being taken this cycle
    logic rem_zero;  // the next byte emitted is the literal
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/lz77_triple_decoder_core.sv -----
// Top level of the LZ77 triple decoder: stream ports, controller and datapath.
// Depends on lztd_pkg, lztd_ctrl and lztd_datapath.
`default_nettype none

// Each input item is one triple (distance, match length, literal). The core
// emits min(match_length, MAX_MATCH) bytes copied from the history window at
// the given distance back, then the literal with tlast set; every emitted byte
// joins the history at once, so copies may overlap their own output. Bytes
// leave at one per cycle when the sink keeps up, set by the single history
// read port and the output register. The next item is taken in the cycle
// its predecessor's literal is written into the output register. Distance
// one is served from a forwarded copy of the last byte. Distance zero or
// beyond WINDOW_SIZE reads as zero. The history reads as zeros after reset
// through per-entry valid bits, so no clearing pass is needed and the core
// accepts items from the first cycle after reset.
module lz77_triple_decoder_core #(
  parameter int unsigned WINDOW_SIZE = lztd_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lztd_pkg::MAX_MATCH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] distance, [11:8] match_length, [19:12] literal, [23:20] zero
  input  wire [lztd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [7:0] out_byte
  output logic [lztd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // is_last
  output logic                            m_axis_tlast
);

  lztd_pkg::cmd_t    cmd;
  lztd_pkg::status_t status;
  logic              busy;

  lztd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  lztd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_MATCH   (MAX_MATCH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_distance_i     (s_axis_tdata[7:0]),
    .in_match_length_i (s_axis_tdata[11:8]),
    .in_literal_i      (s_axis_tdata[19:12]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_byte_o        (m_axis_tdata),
    .out_last_o        (m_axis_tlast)
  );

  // An item taken mid-run follows the literal of the previous one
  a_accept_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && busy) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("item accepted during a run without a closing literal");

  // Any accepted item leaves the core busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> busy)
    else $error("core idle after accepting an item");

  // No byte is emitted while idle
  a_no_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !m_axis_tvalid) |=> !(m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready)))
    else $error("byte emitted without an item in work");

endmodule

`default_nettype wire

// ----- rtl/lztd_ctrl.sv -----
// Sequencer of the LZ77 triple decoder: accepts items and paces byte emission.
// Depends on lztd_pkg for the state type and the command and status structs.
`default_nettype none

module lztd_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  lztd_pkg::status_t status_i,
  output lztd_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  lztd_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lztd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      lztd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lztd_pkg::ST_RUN;
        end
      end
      lztd_pkg::ST_RUN: begin
        cmd_o.step = status_i.out_free;
        // take the next item in the cycle the literal goes out
        if (status_i.out_free && status_i.rem_zero) begin
          in_ready_o = 1'b1;
          cmd_o.load = in_valid_i;
          if (!in_valid_i) begin
            state_d = lztd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lztd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q == lztd_pkg::ST_RUN);

endmodule

`default_nettype wire

// ----- rtl/lztd_datapath.sv -----
// Datapath of the LZ77 triple decoder: item registers, history window,
// write pointer, copy forwarding and the output register.
// Depends on lztd_pkg for widths and the command and status structs.
`default_nettype none

module lztd_datapath #(
  parameter int unsigned WINDOW_SIZE = lztd_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lztd_pkg::MAX_MATCH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lztd_pkg::cmd_t               cmd_i,
  output lztd_pkg::status_t            status_o,
  input  wire [lztd_pkg::DIST_W-1:0]   in_distance_i,
  input  wire [lztd_pkg::LEN_W-1:0]    in_match_length_i,
  input  wire [lztd_pkg::BYTE_W-1:0]   in_literal_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [lztd_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                         out_last_o
);

  localparam int unsigned PosW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned SumW = lztd_pkg::DIST_W + 1;
  localparam int unsigned LenCap = (1 << lztd_pkg::LEN_W) - 1;
  localparam int unsigned SatLen = (MAX_MATCH < LenCap) ? MAX_MATCH : LenCap;
  localparam logic [lztd_pkg::LEN_W-1:0] MaxLen = lztd_pkg::LEN_W'(SatLen);
  localparam logic [lztd_pkg::DIST_W-1:0] WinDist = lztd_pkg::DIST_W'(WINDOW_SIZE);
  localparam logic [SumW-1:0] WinSum = SumW'(WINDOW_SIZE);
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_SIZE - 1);

  // History window and per-entry valid bits (an invalid entry reads as zero)
  logic [lztd_pkg::BYTE_W-1:0] hist_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]      hist_vld_q;

  logic [lztd_pkg::DIST_W-1:0] dist_q;
  logic [lztd_pkg::BYTE_W-1:0] lit_q;
  logic [lztd_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [PosW-1:0]             wr_pos_q, wr_pos_d;
  logic [lztd_pkg::BYTE_W-1:0] last_q;
  logic [lztd_pkg::BYTE_W-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic [lztd_pkg::BYTE_W-1:0] out_byte_q;
  logic                        out_last_q;
  logic                        out_valid_q;

  logic [lztd_pkg::LEN_W-1:0]  len_sat;
  logic [lztd_pkg::DIST_W-1:0] rd_dist;
  logic [SumW-1:0]             rd_sum;
  logic [SumW-1:0]             rd_wrap;
  logic [PosW-1:0]             rd_addr;
  logic                        rd_en;
  logic                        dist_none;
  logic                        dist_one;
  logic [lztd_pkg::BYTE_W-1:0] copy_byte;
  logic [lztd_pkg::BYTE_W-1:0] emit_byte;
  logic                        emit_last;

  // Saturate the match length
  assign len_sat = (in_match_length_i > MaxLen) ? MaxLen : in_match_length_i;

  // Advance the write pointer once per emitted byte
  always_comb begin
    wr_pos_d = wr_pos_q;
    if (cmd_i.step) begin
      wr_pos_d = (wr_pos_q == LastPos) ? '0 : wr_pos_q + PosW'(1);
    end
  end

  // Read address of the next copied byte, relative to the pointer after this cycle
  assign rd_dist = cmd_i.load ? in_distance_i : dist_q;
  assign rd_sum  = SumW'(wr_pos_d) + WinSum - SumW'(rd_dist);
  assign rd_wrap = (rd_sum >= WinSum) ? rd_sum - WinSum : rd_sum;
  assign rd_addr = rd_wrap[PosW-1:0];
  assign rd_en   = cmd_i.load || cmd_i.step;

  // Copied byte: zero out of range, forward the last byte at distance one
  assign dist_none = (dist_q == '0) || (dist_q > WinDist);
  assign dist_one  = (dist_q == lztd_pkg::DIST_W'(1));
  always_comb begin
    if (dist_none) begin
      copy_byte = '0;
    end else if (dist_one) begin
      copy_byte = last_q;
    end else begin
      copy_byte = rd_vld_q ? rd_data_q : '0;
    end
  end

  assign emit_last = (rem_q == '0);
  assign emit_byte = emit_last ? lit_q : copy_byte;

  // Remaining copy count
  always_comb begin
    rem_d = rem_q;
    if (cmd_i.step && !emit_last) begin
      rem_d = rem_q - lztd_pkg::LEN_W'(1);
    end
    if (cmd_i.load) begin
      rem_d = len_sat;
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dist_q <= in_distance_i;
      lit_q  <= in_literal_i;
    end
  end

  // Control state: count, pointer, valid bits, last byte, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      wr_pos_q    <= '0;
      hist_vld_q  <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      wr_pos_q <= wr_pos_d;
      if (cmd_i.step) begin
        hist_vld_q[wr_pos_q] <= 1'b1;
        last_q               <= emit_byte;
        out_valid_q          <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // History write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      hist_mem[wr_pos_q] <= emit_byte;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
      rd_vld_q  <= hist_vld_q[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.rem_zero = emit_last;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- bench/lztd_stream_checker.sv -----
// Stream checker for the LZ77 triple decoder: watches both channels, predicts each byte.
// Depends on lztd_pkg for field widths and the window and match defaults.
`timescale 1ns / 100ps

module lztd_stream_checker #(
  parameter int unsigned WINDOW_SIZE = lztd_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lztd_pkg::MAX_MATCH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_tvalid_i,
  input  wire                            s_tready_i,
  // [7:0] distance, [11:8] match_length, [19:12] literal, [23:20] zero
  input  wire [lztd_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire                            m_tvalid_i,
  input  wire                            m_tready_i,
  // [7:0] out_byte
  input  wire [lztd_pkg::M_TDATA_W-1:0]  m_tdata_i,
  // is_last
  input  wire                            m_tlast_i,
  output int                             fail_count_o,
  output int                             expected_left_o
);

  // Bit offsets of the triple fields inside tdata
  localparam int unsigned LEN_LSB = lztd_pkg::DIST_W;
  localparam int unsigned LIT_LSB = lztd_pkg::DIST_W + lztd_pkg::LEN_W;

  typedef struct packed {
    logic [lztd_pkg::BYTE_W-1:0] data;
    logic                        last;
  } out_beat_t;

  // Decoder model: history window, write pointer and bytes still owed
  logic [lztd_pkg::BYTE_W-1:0] window_mem [WINDOW_SIZE];
  int unsigned                 wr_ptr;
  out_beat_t                   pending_bytes [$];

  task automatic report_mismatch(input string what,
                                 input logic [lztd_pkg::BYTE_W-1:0] got,
                                 input logic [lztd_pkg::BYTE_W-1:0] want);
    $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Append one decoded byte to the window and owe it on the output
  task automatic push_byte(input logic [lztd_pkg::BYTE_W-1:0] b, input logic last);
    out_beat_t beat;
    beat = '{data: b, last: last};
    window_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % WINDOW_SIZE;
    pending_bytes = {pending_bytes, beat};
  endtask

  // Expand one triple into its copied bytes and the closing literal
  task automatic decode_triple(input logic [lztd_pkg::S_TDATA_W-1:0] word);
    logic [lztd_pkg::DIST_W-1:0] back_dist;
    logic [lztd_pkg::BYTE_W-1:0] lit;
    logic [lztd_pkg::BYTE_W-1:0] copied;
    int unsigned                 run;
    back_dist = word[lztd_pkg::DIST_W-1:0];
    run       = 32'(word[LEN_LSB +: lztd_pkg::LEN_W]);
    lit       = word[LIT_LSB +: lztd_pkg::BYTE_W];
    if (run > MAX_MATCH) run = MAX_MATCH;
    for (int unsigned k = 0; k < run; k++) begin
      // zero distance or a distance beyond the window reads as zero
      if (back_dist == 0 || back_dist > WINDOW_SIZE) copied = '0;
      else copied = window_mem[(wr_ptr + WINDOW_SIZE - back_dist) % WINDOW_SIZE];
      push_byte(copied, 1'b0);
    end
    push_byte(lit, 1'b1);
  endtask

  // Compare one output item with the oldest byte owed
  task automatic check_byte();
    out_beat_t want;
    if (pending_bytes.size() == 0) begin
      report_mismatch("output item with nothing expected", m_tdata_i, '0);
    end else begin
      want = pending_bytes.pop_front();
      if (m_tdata_i !== want.data) report_mismatch("out_byte", m_tdata_i, want.data);
      if (m_tlast_i !== want.last) begin
        report_mismatch("is_last", lztd_pkg::BYTE_W'(m_tlast_i),
                        lztd_pkg::BYTE_W'(want.last));
      end
    end
  endtask

  // Predict on input items first, so a same-edge output sees current state
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_SIZE; i++) window_mem[i] = '0;
      wr_ptr = 0;
      pending_bytes.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) decode_triple(s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_byte();
    end
    expected_left_o = pending_bytes.size();
  end

endmodule

// ----- bench/tb_lz77_triple_decoder_core.sv -----
// Testbench top for lz77_triple_decoder_core: clock, reset, triple stimulus, sink stalls.
// Depends on lztd_pkg, the core RTL and lztd_stream_checker.
`timescale 1ns / 100ps

module tb_lz77_triple_decoder_core;

  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 120;
  localparam longint      LIMIT_NS    = 2_000_000;
  localparam int unsigned PAD_W       = lztd_pkg::S_TDATA_W - lztd_pkg::DIST_W
                                        - lztd_pkg::LEN_W - lztd_pkg::BYTE_W;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic [lztd_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                           m_axis_tready = 1'b0;
  wire                            s_axis_tready;
  wire                            m_axis_tvalid;
  wire  [lztd_pkg::M_TDATA_W-1:0] m_axis_tdata;
  wire                            m_axis_tlast;

  int fail_count;
  int expected_left;
  int unsigned sent_count = 0;

  lz77_triple_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lztd_stream_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one triple and hold it until the core takes it
  task automatic send_triple(input logic [lztd_pkg::DIST_W-1:0] back_dist,
                             input logic [lztd_pkg::LEN_W-1:0]  len,
                             input logic [lztd_pkg::BYTE_W-1:0] lit);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, lit, len, back_dist};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  // Random triple, weighted towards short distances as real streams are
  task automatic send_random();
    logic [lztd_pkg::DIST_W-1:0] back_dist;
    logic [lztd_pkg::LEN_W-1:0]  len;
    int unsigned                 pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) back_dist = lztd_pkg::DIST_W'($urandom_range(1, 16));
    else if (pick < 8) back_dist = lztd_pkg::DIST_W'($urandom_range(0, 255));
    else if (pick == 8) back_dist = '0;
    else back_dist = lztd_pkg::DIST_W'($urandom_range(240, 255));
    len = ($urandom_range(0, 4) == 0) ? '0 : lztd_pkg::LEN_W'($urandom_range(0, 15));
    send_triple(back_dist, len, lztd_pkg::BYTE_W'($urandom));
  endtask

  task automatic idle_gap(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold until every owed byte has left the core
  task automatic drain_outputs();
    @(negedge clk_i);
    wait (expected_left == 0);
  endtask

  // Sink: stall on a changing pattern, with one long hold-off mid-run
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned rx_mode;
    bit          hold_done;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned n_rand;
    int unsigned burst;
    int unsigned gap;
    n_rand = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero distance and reads of the freshly reset window
    send_triple(8'd0, 4'd15, 8'hFF);
    send_triple(8'd255, 4'd15, 8'h00);
    send_triple(8'd0, 4'd0, 8'h00);
    // Overlapping copies at distances one to three, empty matches and far reads
    send_triple(8'd1, 4'd15, 8'h5A);
    send_triple(8'd1, 4'd0, 8'hA5);
    send_triple(8'd1, 4'd15, 8'h3C);
    send_triple(8'd2, 4'd9, 8'hC3);
    send_triple(8'd3, 4'd4, 8'h81);
    send_triple(8'd128, 4'd1, 8'h7E);
    send_triple(8'd255, 4'd0, 8'h01);
    // Long copies at the far edge of the window until it wraps
    for (int i = 0; i < 12; i++) begin
      send_triple(8'd255 - 8'(i), 4'd15, 8'h10 + 8'(i));
    end

    // Random bursts with random gaps; one full drain half way through
    while (n_rand < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n_rand < RAND_ITEMS; k++) begin
        send_random();
        n_rand++;
        if (n_rand == RAND_ITEMS / 2) begin
          s_axis_tvalid <= 1'b0;
          drain_outputs();
          @(posedge clk_i);
        end
      end
      gap = $urandom_range(0, 9);
      if (gap >= 3) begin
        idle_gap((gap == 9) ? $urandom_range(20, 40) : $urandom_range(1, 8));
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_left == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_NS;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
